[sv/stam_pkg.sv]
package stam_pkg;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // The tile store is held as rows of eight bytes: 8 tiles x 16 rows x 2 halves.
  localparam int unsigned ROW_BYTES = 8;
  localparam int unsigned ROWS      = 256;
  localparam int unsigned ROW_AW    = 8;
  localparam int unsigned LANE_W    = 3;
  localparam int unsigned ROW_W     = ROW_BYTES * 8;

  typedef enum logic [1:0] {
    OP_CAN   = 2'd0,
    OP_LOCAL = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] can_id;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;
    logic [10:0] position;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       accepted;
  } result_t;

  typedef struct packed {
    cmd_e              kind;
    logic              accepted;
    logic [ROW_AW-1:0] row;
    logic [ROW_BYTES-1:0] be;
    logic [ROW_W-1:0]  wdata;
    logic [LANE_W-1:0] lane;
  } cmd_t;

endpackage

[sv/stam_front.sv]
module stam_front import stam_pkg::*; (
  input  item_t item_i,
  output cmd_t  cmd_o
);

  logic [2:0]  head;
  logic [7:0]  low;
  logic [2:0]  can_tile;
  logic [1:0]  blk;
  logic [2:0]  rd_tile;
  logic [3:0]  rd_col;

  assign head     = item_i.can_id[10:8];
  assign low      = item_i.can_id[7:0];
  assign can_tile = (head == 3'd1) ? 3'd7 : head - 3'd1;

  // Remapped view: the upper half of a column comes mirrored from tiles 4..7,
  // the lower half straight from tiles 3..0.
  assign blk     = item_i.position[10:9];
  assign rd_tile = item_i.position[4] ? (3'd3 - {1'b0, blk}) : {1'b1, blk};
  assign rd_col  = item_i.position[4] ? item_i.position[3:0] : ~item_i.position[3:0];

  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = CMD_NONE;
    case (op_e'(item_i.op))
      OP_CAN: begin
        if (head != 3'd0 && low[7:5] == 3'd0) begin
          cmd_o.kind     = CMD_WRITE;
          cmd_o.accepted = 1'b1;
          cmd_o.row      = {can_tile, low[4:0]};
          cmd_o.be       = '1;
          cmd_o.wdata    = {item_i.byte_7, item_i.byte_6, item_i.byte_5, item_i.byte_4,
                            item_i.byte_3, item_i.byte_2, item_i.byte_1, item_i.byte_0};
        end
      end
      OP_LOCAL: begin
        cmd_o.kind     = CMD_WRITE;
        cmd_o.accepted = 1'b1;
        cmd_o.row      = {3'd0, item_i.position[7:3]};
        cmd_o.be       = ROW_BYTES'(1) << item_i.position[2:0];
        cmd_o.wdata    = {ROW_BYTES{item_i.byte_0}};
      end
      OP_READ: begin
        cmd_o.kind     = CMD_READ;
        cmd_o.accepted = 1'b1;
        cmd_o.row      = {rd_tile, item_i.position[8:5], rd_col[3]};
        cmd_o.lane     = rd_col[2:0];
      end
      default: begin
        cmd_o.kind = CMD_NONE;
      end
    endcase
  end

endmodule

[sv/stam_queue.sv]
module stam_queue import stam_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o || pop_i)
    else $error("queue written while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("queue read while empty");
`endif

endmodule

[sv/stam_back.sv]
module stam_back import stam_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    pop_o,
  output logic    done_o,
  output result_t result_o
);

  logic [ROW_W-1:0]     mem_q [ROWS];
  logic [ROWS-1:0]      row_valid_q;
  logic [ROW_W-1:0]     rdata_q;
  logic                 we, re;
  logic [ROW_BYTES-1:0] be_eff;
  logic [ROW_W-1:0]     wdata_eff;

  logic                 go_q;
  logic                 rd_q;
  logic                 acc_q;
  logic                 rvalid_q;
  logic [LANE_W-1:0]    lane_q;
  logic                 done_q;
  result_t              result_q, result_d;

  // The back never stalls, so it takes every command as soon as one is queued.
  assign pop_o = cmd_valid_i;
  assign we    = cmd_valid_i && (cmd_i.kind == CMD_WRITE);
  assign re    = cmd_valid_i && (cmd_i.kind == CMD_READ);

  // A row not yet written holds zeros: its first write fills every lane.
  always_comb begin
    be_eff    = row_valid_q[cmd_i.row] ? cmd_i.be : '1;
    wdata_eff = '0;
    for (int i = 0; i < ROW_BYTES; i++) begin
      if (cmd_i.be[i]) begin
        wdata_eff[8*i +: 8] = cmd_i.wdata[8*i +: 8];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      for (int i = 0; i < ROW_BYTES; i++) begin
        if (be_eff[i]) begin
          mem_q[cmd_i.row][8*i +: 8] <= wdata_eff[8*i +: 8];
        end
      end
    end
    if (re) begin
      rdata_q <= mem_q[cmd_i.row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      go_q        <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (we) begin
        row_valid_q[cmd_i.row] <= 1'b1;
      end
      go_q   <= cmd_valid_i;
      done_q <= go_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      rd_q     <= (cmd_i.kind == CMD_READ);
      acc_q    <= cmd_i.accepted;
      rvalid_q <= row_valid_q[cmd_i.row];
      lane_q   <= cmd_i.lane;
    end
    if (go_q) begin
      result_q <= result_d;
    end
  end

  always_comb begin
    result_d.read_value = (rd_q && rvalid_q) ? rdata_q[{lane_q, 3'b000} +: 8] : 8'h00;
    result_d.accepted   = acc_q;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) we |=> row_valid_q[$past(cmd_i.row)])
    else $error("written row not marked valid");
`endif

endmodule

[sv/sensor_tile_assembler_remap.sv]
// Channel    Ports                        Handshake
// command    start, busy, item_i          beat taken when start is high and busy low
// result     done_o, result_o             one beat per command, done_o high one cycle
//
// One command can be taken in every cycle while busy is low. Each result follows its
// command beat through the command queue, the registered read of the single-port row
// memory, and the result register.
// The tile store is 256 rows of eight bytes; a valid bit per row, cleared at reset,
// makes unwritten rows read as zero, so there is no clearing pass after reset.
// The receiver cannot stall; the back drains the queue every cycle, so busy is only
// raised if the queue ever fills.
module sensor_tile_assembler_remap import stam_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  item_t   item_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic push;
  logic full;
  logic queue_valid;
  logic pop;

  // A beat is pushed straight into the queue once the front has decoded it.
  assign push = start && !busy;
  assign busy = full;

  // The front decodes the operation into a row address, byte enables, data and a read lane.
  stam_front u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  // The queue decouples decoding from the memory side.
  stam_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // The back owns the tile store and produces one result per command.
  stam_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .done_o      (done_o),
    .result_o    (result_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |-> ##3 done_o)
    else $error("result missing three cycles after a command beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(start && !busy, 3))
    else $error("result without a matching command beat");
`endif

endmodule

[verif/sensor_tile_assembler_remap_tb.sv]
module sensor_tile_assembler_remap_tb import stam_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Op code 3 is not used by the block. It is kept here so that it can be
  // sent as noise and checked to leave the store alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned STORE_SIZE   = 2048;
  localparam int unsigned COMMAND_TOTAL = 1900;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  item_t   item_i = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  // Commands wait here until the driver puts them on the bus.
  item_t   queued_commands [$];
  // Replies predicted for commands that the block has taken but not answered.
  result_t awaited_replies [$];
  // Our own copy of the eight pressure tiles, addressed as tile*256 + row*16 + col.
  logic [7:0] store_shadow [STORE_SIZE];

  int unsigned mismatch_count = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  sensor_tile_assembler_remap dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .item_i   (item_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Works out the reply to one command and applies any write it makes to the
  // shadow store. It must be called exactly once per accepted beat, in order.
  function automatic result_t predict_reply(input item_t cmd);
    result_t     reply;
    logic [2:0]  head;
    logic [7:0]  low;
    logic [2:0]  tile;
    logic [63:0] payload;
    logic [5:0]  view_col;
    logic [4:0]  view_row;
    logic [1:0]  blk;
    logic [3:0]  tile_row;
    logic [10:0] addr;
    reply   = '0;
    payload = {cmd.byte_0, cmd.byte_1, cmd.byte_2, cmd.byte_3,
               cmd.byte_4, cmd.byte_5, cmd.byte_6, cmd.byte_7};
    case (cmd.op)
      OP_CAN: begin
        head = cmd.can_id[10:8];
        low  = cmd.can_id[7:0];
        // A frame only lands if its id names one of the seven remote tiles and
        // one of the 32 half-rows; the head value 1 stands for the last tile.
        if (head != 3'd0 && low < 8'd32) begin
          tile = (head == 3'd1) ? 3'd7 : head - 3'd1;
          for (int i = 0; i < 8; i++) begin
            store_shadow[{tile, low[4:1], low[0], 3'(i)}] = payload[63 - 8*i -: 8];
          end
          reply.accepted = 1'b1;
        end
      end
      OP_LOCAL: begin
        // Only the low byte of the position counts, so large values wrap in tile 0.
        store_shadow[{3'd0, cmd.position[7:0]}] = cmd.byte_0;
        reply.accepted = 1'b1;
      end
      OP_READ: begin
        view_col = cmd.position[10:5];
        view_row = cmd.position[4:0];
        blk      = view_col[5:4];
        tile_row = view_col[3:0];
        // The upper half of each view column reads the right-hand tiles mirrored,
        // the lower half reads the left-hand tiles straight.
        if (view_row < 5'd16) begin
          tile = 3'd4 + {1'b0, blk};
          addr = {tile, tile_row, 4'd15 - view_row[3:0]};
        end else begin
          tile = 3'd3 - {1'b0, blk};
          addr = {tile, tile_row, view_row[3:0]};
        end
        reply.read_value = store_shadow[addr];
        reply.accepted   = 1'b1;
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic item_t make_command(input logic [1:0] op, input logic [10:0] can_id,
                                         input logic [63:0] payload,
                                         input logic [10:0] position);
    item_t cmd;
    cmd.op       = op;
    cmd.can_id   = can_id;
    {cmd.byte_0, cmd.byte_1, cmd.byte_2, cmd.byte_3,
     cmd.byte_4, cmd.byte_5, cmd.byte_6, cmd.byte_7} = payload;
    cmd.position = position;
    return cmd;
  endfunction

  // Position of a byte in the 64 x 32 view, column-major.
  function automatic logic [10:0] view_pos(input int unsigned col, input int unsigned row);
    return 11'(col * 32 + row);
  endfunction

  // The driver hands out commands in bursts of random length, with random
  // gaps between them. A beat is taken when start is high and busy is low;
  // while busy holds the beat off, the command and start stay as they are.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        awaited_replies.push_back(predict_reply(item_i));
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (queued_commands.size() != 0) begin
          item_i <= queued_commands.pop_front();
          start  <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // About a quarter of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // The monitor takes every reply beat marked by done_o and compares it, field
  // by field, with the oldest prediction. The receiver cannot stall the block,
  // so every beat is taken as it comes.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual value %0h accepted %0b",
                 $time, result_o.read_value, result_o.accepted);
        mismatch_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (result_o.read_value !== want.read_value) begin
          $display("%0t: read_value mismatch, expected %0h, actual %0h",
                   $time, want.read_value, result_o.read_value);
          mismatch_count++;
        end
        if (result_o.accepted !== want.accepted) begin
          $display("%0t: accepted mismatch, expected %0b, actual %0b",
                   $time, want.accepted, result_o.accepted);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    item_t       cmd;
    int unsigned useful;
    int unsigned pick;

    for (int i = 0; i < STORE_SIZE; i++) begin
      store_shadow[i] = 8'h00;
    end

    // Directed part. Reads of untouched tiles come first and must give zero.
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(0, 0)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, 11'h7FF));
    // Frames into the first and last half-rows, and the head value that maps
    // onto the last tile.
    queued_commands.push_back(make_command(OP_CAN, {3'd1, 8'd0},
                                           64'h00FF_0180_7F55_AA01, '0));
    queued_commands.push_back(make_command(OP_CAN, {3'd7, 8'd31}, '1, '0));
    queued_commands.push_back(make_command(OP_CAN, {3'd3, 8'd2},
                                           64'h0123_4567_89AB_CDEF, '0));
    queued_commands.push_back(make_command(OP_CAN, {3'd2, 8'd0},
                                           64'hFEDC_BA98_7654_3210, '0));
    // Frames whose id matches no slot: head zero, low part far too large,
    // and low part just past the last half-row.
    queued_commands.push_back(make_command(OP_CAN, {3'd0, 8'd5}, '1, '0));
    queued_commands.push_back(make_command(OP_CAN, 11'h7FF, '1, '1));
    queued_commands.push_back(make_command(OP_CAN, {3'd4, 8'd32}, '1, '0));
    // Local samples, including positions beyond tile 0 that must wrap.
    queued_commands.push_back(make_command(OP_LOCAL, '0, 64'hFF00_0000_0000_0000, 11'd0));
    queued_commands.push_back(make_command(OP_LOCAL, '0, 64'h5A00_0000_0000_0000, 11'd255));
    queued_commands.push_back(make_command(OP_LOCAL, '0, 64'h3C00_0000_0000_0000, 11'h7FF));
    queued_commands.push_back(make_command(OP_LOCAL, '0, 64'h8100_0000_0000_0000, 11'h100));
    // The unused op with every field at its top value.
    queued_commands.push_back(make_command(OP_UNUSED, '1, '1, '1));
    // Read back what was written, through both halves of the view.
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(48, 15)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(48, 8)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(47, 0)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(47, 7)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(17, 19)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(32, 16)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(63, 31)));
    queued_commands.push_back(make_command(OP_READ, '0, '0, view_pos(48, 16)));

    // Random part. Most frames carry a matching id so that all seven remote
    // tiles fill up; reads then sweep the whole view. Unmatched frames and the
    // unused op are sprinkled in as noise and are not counted.
    useful = 0;
    while (useful < COMMAND_TOTAL) begin
      cmd.can_id   = 11'($urandom_range(0, 2047));
      {cmd.byte_0, cmd.byte_1, cmd.byte_2, cmd.byte_3,
       cmd.byte_4, cmd.byte_5, cmd.byte_6, cmd.byte_7} = {$urandom, $urandom};
      cmd.position = 11'($urandom_range(0, 2047));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        cmd.op     = OP_CAN;
        cmd.can_id = {3'($urandom_range(1, 7)), 8'($urandom_range(0, 31))};
      end else if (pick < 46) begin
        cmd.op = OP_CAN;
      end else if (pick < 64) begin
        cmd.op = OP_LOCAL;
        if (pick < 55) begin
          cmd.position[10:8] = 3'd0;
        end
      end else if (pick < 97) begin
        cmd.op = OP_READ;
      end else begin
        cmd.op = OP_UNUSED;
      end
      queued_commands.push_back(cmd);
      if (cmd.op == OP_LOCAL || cmd.op == OP_READ ||
          (cmd.op == OP_CAN && cmd.can_id[10:8] != 3'd0 && cmd.can_id[7:0] < 8'd32)) begin
        useful++;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last beat to be taken, then for every reply, and then keep the
    // clock running so that a stray reply would still be caught.
    while (queued_commands.size() != 0 || start) @(posedge clk_i);
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // A run that hangs is stopped here and reported as a mismatch.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
sv/stam_pkg.sv
sv/stam_front.sv
sv/stam_queue.sv
sv/stam_back.sv
sv/sensor_tile_assembler_remap.sv
verif/sensor_tile_assembler_remap_tb.sv
